[design/agps_pkg.sv]
package agps_pkg;

  localparam int SIZE_BITS  = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int COLOR_W    = 32;
  // period = (inner + border) << FRAC_BITS
  localparam int PER_W      = SIZE_BITS + 1 + FRAC_BITS;
  localparam int CELL_W     = SIZE_BITS + 1;

  // restoring divider: dividend, divisor, one quotient bit per stage
  localparam int DIV_N_W    = COORD_W + FRAC_BITS;
  localparam int DIV_D_W    = COORD_W;
  localparam int DIV_STAGES = DIV_N_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_INNER_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_H     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_V     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INNER_COLOR  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_COLOR = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_PROJECTIVE   = 3'd6;

  typedef struct packed {
    logic [SIZE_BITS-1:0] inner_width;
    logic [SIZE_BITS-1:0] inner_height;
    logic [SIZE_BITS-1:0] border_h_thickness;
    logic [SIZE_BITS-1:0] border_v_thickness;
    logic [COLOR_W-1:0]   inner_color;
    logic [COLOR_W-1:0]   border_color;
    logic                 projective_mode;
  } cfg_t;

  // entry of the queue between front and back
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               force_border;
    logic               fault;
  } fq_t;

endpackage

[design/agps_div.sv]
module agps_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [agps_pkg::DIV_N_W-1:0]  n_in,
  input  logic [agps_pkg::DIV_D_W-1:0]  d_in,
  output logic [agps_pkg::DIV_N_W-1:0]  q_out,
  output logic [agps_pkg::DIV_D_W-1:0]  r_out
);
  import agps_pkg::*;

  // num shifts dividend bits out at the top and quotient bits in at the bottom
  logic [DIV_D_W-1:0] rem [1:DIV_STAGES];
  logic [DIV_N_W-1:0] num [1:DIV_STAGES];
  logic [DIV_D_W-1:0] den [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DIV_D_W-1:0] r_i;
    logic [DIV_N_W-1:0] n_i;
    logic [DIV_D_W-1:0] d_i;
    logic [DIV_D_W:0]   t;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign r_i = '0;
      assign n_i = n_in;
      assign d_i = d_in;
    end else begin : g_next
      assign r_i = rem[k];
      assign n_i = num[k];
      assign d_i = den[k];
    end

    assign t    = {r_i, n_i[DIV_N_W-1]};
    assign ge   = t >= {1'b0, d_i};
    assign diff = t - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DIV_D_W-1:0] : t[DIV_D_W-1:0];
        num[k+1] <= {n_i[DIV_N_W-2:0], ge};
        den[k+1] <= d_i;
      end
    end
  end

  assign q_out = num[DIV_STAGES];
  assign r_out = rem[DIV_STAGES];

endmodule

[design/agps_fifo.sv]
module agps_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  agps_pkg::fq_t   din,
  input  logic            pop,
  output agps_pkg::fq_t   dout,
  output logic            full,
  output logic            empty
);
  import agps_pkg::*;

  fq_t                  entries [0:FIFO_DEPTH-1];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full  = count == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

[design/agps_front.sv]
module agps_front (
  input  logic                          clk,
  input  logic                          rst,
  input  agps_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [agps_pkg::COORD_W-1:0]  x_coord,
  input  logic [agps_pkg::COORD_W-1:0]  y_coord,
  input  logic [agps_pkg::COORD_W-1:0]  w_coord,
  input  logic                          fifo_full,
  output logic                          push,
  output agps_pkg::fq_t                 push_data
);
  import agps_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x_raw;
    logic [COORD_W-1:0] y_raw;
    logic               proj;
    logic               negx;
    logic               negy;
    logic               force_border;
    logic               fault;
  } fmeta_t;

  fmeta_t             meta_sr [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] vld;
  fmeta_t             meta_in;
  logic               en;
  logic               disabled;
  logic [COORD_W-1:0] mag_x;
  logic [COORD_W-1:0] mag_y;
  logic [COORD_W-1:0] mag_w;
  logic [DIV_N_W-1:0] qx;
  logic [DIV_N_W-1:0] qy;
  logic [DIV_D_W-1:0] rx_unused;
  logic [DIV_D_W-1:0] ry_unused;
  fmeta_t             last;

  assign en       = !(vld[DIV_STAGES-1] && fifo_full);
  assign in_stall = !en;

  assign disabled = (cfg.inner_width == '0) || (cfg.inner_height == '0) ||
                    (cfg.border_h_thickness == '0) || (cfg.border_v_thickness == '0);

  assign mag_x = x_coord[COORD_W-1] ? -x_coord : x_coord;
  assign mag_y = y_coord[COORD_W-1] ? -y_coord : y_coord;
  assign mag_w = w_coord[COORD_W-1] ? -w_coord : w_coord;

  always_comb begin
    meta_in.x_raw        = x_coord;
    meta_in.y_raw        = y_coord;
    meta_in.proj         = cfg.projective_mode;
    meta_in.negx         = x_coord[COORD_W-1] ^ w_coord[COORD_W-1];
    meta_in.negy         = y_coord[COORD_W-1] ^ w_coord[COORD_W-1];
    meta_in.fault        = !disabled && cfg.projective_mode && (w_coord == '0);
    meta_in.force_border = disabled || meta_in.fault;
  end

  agps_div u_div_x (
    .clk   (clk),
    .en    (en),
    .n_in  ({mag_x, FRAC_BITS'(0)}),
    .d_in  (mag_w),
    .q_out (qx),
    .r_out (rx_unused)
  );

  agps_div u_div_y (
    .clk   (clk),
    .en    (en),
    .n_in  ({mag_y, FRAC_BITS'(0)}),
    .d_in  (mag_w),
    .q_out (qy),
    .r_out (ry_unused)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      meta_sr[0] <= meta_in;
      for (int k = 1; k < DIV_STAGES; k++) begin
        meta_sr[k] <= meta_sr[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], in_valid};
    end
  end

  assign last = meta_sr[DIV_STAGES-1];
  assign push = vld[DIV_STAGES-1] && en;

  always_comb begin
    push_data.force_border = last.force_border;
    push_data.fault        = last.fault;
    if (last.proj) begin
      push_data.x = last.negx ? -qx[COORD_W-1:0] : qx[COORD_W-1:0];
      push_data.y = last.negy ? -qy[COORD_W-1:0] : qy[COORD_W-1:0];
    end else begin
      push_data.x = last.x_raw;
      push_data.y = last.y_raw;
    end
  end

endmodule

[design/agps_back.sv]
module agps_back (
  input  logic                          clk,
  input  logic                          rst,
  input  agps_pkg::cfg_t                cfg,
  input  logic                          fifo_empty,
  input  agps_pkg::fq_t                 head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [agps_pkg::COLOR_W-1:0]  pixel_color,
  output logic                          divide_fault
);
  import agps_pkg::*;

  typedef struct packed {
    logic negx;
    logic negy;
    logic force_border;
    logic fault;
  } bmeta_t;

  function automatic logic [COLOR_W-1:0] blend256(input logic [8:0] a,
                                                  input logic [COLOR_W-1:0] c0,
                                                  input logic [COLOR_W-1:0] c1);
    logic [COLOR_W-1:0] res;
    logic signed [9:0]  d;
    logic signed [19:0] prod;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      d    = $signed({2'b00, c0[8*i +: 8]}) - $signed({2'b00, c1[8*i +: 8]});
      prod = d * $signed({1'b0, a});
      res[8*i +: 8] = c1[8*i +: 8] + prod[15:8];
    end
    return res;
  endfunction

  bmeta_t                meta_sr [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] vld;
  logic                  en;
  logic [COORD_W-1:0]    mag_x;
  logic [COORD_W-1:0]    mag_y;
  logic [PER_W-1:0]      per_x;
  logic [PER_W-1:0]      per_y;
  logic [PER_W-1:0]      lim_x;
  logic [PER_W-1:0]      lim_y;
  logic [DIV_N_W-1:0]    qx_unused;
  logic [DIV_N_W-1:0]    qy_unused;
  logic [DIV_D_W-1:0]    rx;
  logic [DIV_D_W-1:0]    ry;
  bmeta_t                m_last;

  // stage A: floored remainders
  logic                  va;
  logic [PER_W-1:0]      sx_f;
  logic [PER_W-1:0]      sy_f;
  bmeta_t                ma;

  // stage B: border test and column blend
  logic                  vb;
  logic                  border_b;
  logic                  fault_b;
  logic [COLOR_W-1:0]    col_b;
  logic [PER_W-1:0]      sy_f_b;

  // stage C: row blend, output register
  logic                  vc;
  logic [COLOR_W-1:0]    color_c;
  logic                  fault_c;

  logic [CELL_W-1:0]     sx;
  logic [CELL_W-1:0]     sy;
  logic [8:0]            ax;
  logic [8:0]            ay;
  logic [COLOR_W-1:0]    col_x;
  logic [COLOR_W-1:0]    col_y;

  assign en  = !(vc && out_stall);
  assign pop = !fifo_empty && en;

  assign mag_x = head.x[COORD_W-1] ? -head.x : head.x;
  assign mag_y = head.y[COORD_W-1] ? -head.y : head.y;

  assign per_x = {CELL_W'(cfg.inner_width) + CELL_W'(cfg.border_v_thickness), FRAC_BITS'(0)};
  assign per_y = {CELL_W'(cfg.inner_height) + CELL_W'(cfg.border_h_thickness), FRAC_BITS'(0)};
  assign lim_x = {1'b0, cfg.inner_width, FRAC_BITS'(0)};
  assign lim_y = {1'b0, cfg.inner_height, FRAC_BITS'(0)};

  agps_div u_mod_x (
    .clk   (clk),
    .en    (en),
    .n_in  (DIV_N_W'(mag_x)),
    .d_in  (DIV_D_W'(per_x)),
    .q_out (qx_unused),
    .r_out (rx)
  );

  agps_div u_mod_y (
    .clk   (clk),
    .en    (en),
    .n_in  (DIV_N_W'(mag_y)),
    .d_in  (DIV_D_W'(per_y)),
    .q_out (qy_unused),
    .r_out (ry)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      meta_sr[0] <= '{negx: head.x[COORD_W-1], negy: head.y[COORD_W-1],
                      force_border: head.force_border, fault: head.fault};
      for (int k = 1; k < DIV_STAGES; k++) begin
        meta_sr[k] <= meta_sr[k-1];
      end
    end
  end

  assign m_last = meta_sr[DIV_STAGES-1];

  // remainder is below the period, so it fits PER_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= m_last;
      sx_f <= (m_last.negx && rx != '0) ? per_x - rx[PER_W-1:0] : rx[PER_W-1:0];
      sy_f <= (m_last.negy && ry != '0) ? per_y - ry[PER_W-1:0] : ry[PER_W-1:0];
    end
  end

  assign sx = sx_f[PER_W-1:FRAC_BITS];
  assign ax = 9'd1 + 9'(sx_f[FRAC_BITS-1:FRAC_BITS-8]);

  always_comb begin
    if (sx == '0) begin
      col_x = blend256(ax, cfg.inner_color, cfg.border_color);
    end else if (sx == CELL_W'(cfg.inner_width) - 1'b1) begin
      col_x = blend256(ax, cfg.border_color, cfg.inner_color);
    end else begin
      col_x = cfg.inner_color;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      border_b <= ma.force_border || (sy_f >= lim_y) || (sx_f >= lim_x);
      fault_b  <= ma.fault;
      col_b    <= col_x;
      sy_f_b   <= sy_f;
    end
  end

  assign sy = sy_f_b[PER_W-1:FRAC_BITS];
  assign ay = 9'd1 + 9'(sy_f_b[FRAC_BITS-1:FRAC_BITS-8]);

  always_comb begin
    if (border_b) begin
      col_y = cfg.border_color;
    end else if (sy == '0) begin
      col_y = blend256(ay, col_b, cfg.border_color);
    end else if (sy == CELL_W'(cfg.inner_height) - 1'b1) begin
      col_y = blend256(ay, cfg.border_color, col_b);
    end else begin
      col_y = col_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color_c <= col_y;
      fault_c <= fault_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      va  <= 1'b0;
      vb  <= 1'b0;
      vc  <= 1'b0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], !fifo_empty};
      va  <= vld[DIV_STAGES-1];
      vb  <= va;
      vc  <= vb;
    end
  end

  assign out_valid    = vc;
  assign pixel_color  = color_c;
  assign divide_fault = fault_c;

endmodule

[design/antialiased_grid_pattern_shader.sv]
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_stall    x_coord, y_coord, w_coord (signed 16.16)
// out      out  out_valid/out_stall  pixel_color (ARGB8888), divide_fault
// cfg      in   APB psel/penable     7 registers at byte address 4*index
//
// One transaction per clock sustained while out_stall stays low; the front
// holds the divider pipeline, the queue is registered, and the back holds the
// 48-stage modulo pipeline plus remainder fix, column blend and row blend.
// rst is synchronous: clears valids and queue pointers; resets the registers.
// out_stall freezes the back only; the front keeps taking transactions until
// the 4-entry queue is full and the front's last stage is valid; in_stall rises.
module antialiased_grid_pattern_shader (
  input  logic                          clk,
  input  logic                          rst,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [agps_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [agps_pkg::COORD_W-1:0]  x_coord,
  input  logic [agps_pkg::COORD_W-1:0]  y_coord,
  input  logic [agps_pkg::COORD_W-1:0]  w_coord,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [agps_pkg::COLOR_W-1:0]  pixel_color,
  output logic                          divide_fault
);
  import agps_pkg::*;

  cfg_t                  cfg;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  idx;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  empty;
  fq_t                   push_data;
  fq_t                   head;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // register file; writes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inner_width        <= SIZE_BITS'(1);
      cfg.inner_height       <= SIZE_BITS'(1);
      cfg.border_h_thickness <= SIZE_BITS'(1);
      cfg.border_v_thickness <= SIZE_BITS'(1);
      cfg.inner_color        <= '0;
      cfg.border_color       <= '0;
      cfg.projective_mode    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_INNER_WIDTH:  cfg.inner_width        <= pwdata[SIZE_BITS-1:0];
        REG_INNER_HEIGHT: cfg.inner_height       <= pwdata[SIZE_BITS-1:0];
        REG_BORDER_H:     cfg.border_h_thickness <= pwdata[SIZE_BITS-1:0];
        REG_BORDER_V:     cfg.border_v_thickness <= pwdata[SIZE_BITS-1:0];
        REG_INNER_COLOR:  cfg.inner_color        <= pwdata;
        REG_BORDER_COLOR: cfg.border_color       <= pwdata;
        REG_PROJECTIVE:   cfg.projective_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INNER_WIDTH:  prdata = 32'(cfg.inner_width);
      REG_INNER_HEIGHT: prdata = 32'(cfg.inner_height);
      REG_BORDER_H:     prdata = 32'(cfg.border_h_thickness);
      REG_BORDER_V:     prdata = 32'(cfg.border_v_thickness);
      REG_INNER_COLOR:  prdata = cfg.inner_color;
      REG_BORDER_COLOR: prdata = cfg.border_color;
      REG_PROJECTIVE:   prdata = 32'(cfg.projective_mode);
      default:          prdata = '0;
    endcase
  end

  // front: classify and do the projective divide
  agps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .w_coord   (w_coord),
    .fifo_full (full),
    .push      (push),
    .push_data (push_data)
  );

  agps_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  // back: cell reduction, border test, edge blending
  agps_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fifo_empty   (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_color  (pixel_color),
    .divide_fault (divide_fault)
  );

endmodule
